// File: hw/rtl/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = 8;

    // s_tuser codes
    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD_J,
        ST_SWAP1,
        ST_SWAP2,
        ST_K_RD,
        ST_K_J,
        ST_K_W1,
        ST_K_W2
    } state_t;

    // one access cycle on the permutation memory
    typedef struct packed {
        logic                we;
        logic [PERM_AW-1:0]  waddr;
        logic [BYTE_W-1:0]   wdata;
        logic [PERM_AW-1:0]  raddr;
    } perm_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/rc4_ram.sv
`default_nettype none

module rc4_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rc4_perm_mem.sv
`default_nettype none

module rc4_perm_mem (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rc4_pkg::perm_req_t            req,
    output logic      [rc4_pkg::BYTE_W-1:0]    rd_data
);

    logic [rc4_pkg::BYTE_W-1:0] ram_q;
    logic                       hit_reg;
    logic [rc4_pkg::BYTE_W-1:0] fwd_data_reg;

    rc4_ram #(
        .DATA_W (rc4_pkg::BYTE_W),
        .ADDR_W (rc4_pkg::PERM_AW),
        .DEPTH  (rc4_pkg::PERM_DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (req.we),
        .wr_addr (req.waddr),
        .wr_data (req.wdata),
        .rd_addr (req.raddr),
        .rd_data (ram_q)
    );

    // forward a write that lands on the entry read in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= req.we && (req.waddr == req.raddr);
        end
        fwd_data_reg <= req.wdata;
    end

    assign rd_data = hit_reg ? fwd_data_reg : ram_q;

endmodule

`default_nettype wire

// File: hw/rtl/rc4_stream_cipher_top.sv
// Channel  | Ports                                   | Contents
// ---------+-----------------------------------------+------------------------------------
// input    | s_tvalid s_tready s_tdata s_tuser s_tlast | tdata = byte_in, tuser = func,
//          |                                         | tlast = last
// result   | m_tvalid m_tready m_tdata m_tlast       | tdata = byte_out, tlast = last_out
//
// A data item runs through these steps: S[i] is read in the accepting cycle, then read S[j], then
// write S[i] and read the output entry, then write S[j] and load the output; the
// single-port-pair permutation memory forces this sequence. The next item can be taken in the last step.
// A key item is stored while there is room, and the block stays idle; a last key item starts the
// schedule: an identity sweep over all 256 entries, then one read step and 256 swap steps.
// After reset the same identity sweep runs before the first item is taken.
// A stalled result is held in the output register; the swap step waits on it.
`default_nettype none

module rc4_stream_cipher_top #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] byte_in
    input  wire logic       s_tuser,   // [0] func
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] byte_out
    output logic            m_tlast
);

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KC_W   = $clog2(MAX_KEY_BYTES + 1);

    typedef logic [rc4_pkg::BYTE_W-1:0] byte_t;

    rc4_pkg::state_t    state_reg, state_next;
    byte_t              i_reg, i_next;
    byte_t              j_reg, j_next;
    byte_t              a_reg, a_next;
    byte_t              t_reg, t_next;
    byte_t              din_reg, din_next;
    logic               dlast_reg, dlast_next;
    logic               sched_reg, sched_next;
    logic [KC_W-1:0]    kcount_reg, kcount_next;
    logic [KC_W-1:0]    klen_reg, klen_next;
    logic [KIDX_W-1:0]  kpos_reg, kpos_next;
    logic               ovalid_reg, ovalid_next;
    byte_t              odata_reg, odata_next;
    logic               olast_reg, olast_next;

    rc4_pkg::perm_req_t perm_req;
    byte_t              perm_rd;
    logic               key_we;
    logic [KIDX_W-1:0]  key_waddr;
    logic [KIDX_W-1:0]  key_raddr;
    byte_t              key_rd;

    logic               out_free;
    logic               accept;
    logic               key_room;
    logic [KC_W-1:0]    kcount_inc;
    logic [KC_W-1:0]    kpos_inc;
    logic [KIDX_W-1:0]  kpos_wrap;
    byte_t              keystream;
    byte_t              j_sched;

    rc4_perm_mem u_perm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (perm_req),
        .rd_data (perm_rd)
    );

    rc4_ram #(
        .DATA_W (rc4_pkg::BYTE_W),
        .ADDR_W (KIDX_W),
        .DEPTH  (MAX_KEY_BYTES)
    ) u_key (
        .clk     (aclk),
        .wr_en   (key_we),
        .wr_addr (key_waddr),
        .wr_data (s_tdata),
        .rd_addr (key_raddr),
        .rd_data (key_rd)
    );

    assign out_free   = !ovalid_reg || m_tready;
    assign s_tready   = (state_reg == rc4_pkg::ST_IDLE)
                     || ((state_reg == rc4_pkg::ST_SWAP2) && out_free);
    assign accept     = s_tvalid && s_tready;
    assign key_room   = kcount_reg < KC_W'(MAX_KEY_BYTES);
    assign kcount_inc = kcount_reg + KC_W'(1);
    assign kpos_inc   = KC_W'(kpos_reg) + KC_W'(1);
    assign kpos_wrap  = (kpos_inc >= klen_reg) ? '0 : kpos_inc[KIDX_W-1:0];
    // S[i] + S[j] may be the entry the pending second swap write is about to change
    assign keystream  = (t_reg == j_reg) ? a_reg : perm_rd;
    assign j_sched    = j_reg + perm_rd + key_rd;

    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        a_next      = a_reg;
        t_next      = t_reg;
        din_next    = din_reg;
        dlast_next  = dlast_reg;
        sched_next  = sched_reg;
        kcount_next = kcount_reg;
        klen_next   = klen_reg;
        kpos_next   = kpos_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;

        perm_req.we    = 1'b0;
        perm_req.waddr = i_reg;
        perm_req.wdata = a_reg;
        perm_req.raddr = i_reg + byte_t'(1);
        key_we         = 1'b0;
        key_waddr      = kcount_reg[KIDX_W-1:0];
        key_raddr      = kpos_reg;

        case (state_reg)
            rc4_pkg::ST_INIT: begin
                // sweep the identity into the permutation
                perm_req.we    = 1'b1;
                perm_req.waddr = i_reg;
                perm_req.wdata = i_reg;
                perm_req.raddr = i_reg;
                i_next         = i_reg + byte_t'(1);
                if (i_reg == byte_t'(rc4_pkg::PERM_DEPTH - 1)) begin
                    sched_next = 1'b0;
                    state_next = sched_reg ? rc4_pkg::ST_K_RD : rc4_pkg::ST_IDLE;
                end
            end
            rc4_pkg::ST_RD_J: begin
                a_next         = perm_rd;
                j_next         = j_reg + perm_rd;
                perm_req.raddr = j_reg + perm_rd;
                state_next     = rc4_pkg::ST_SWAP1;
            end
            rc4_pkg::ST_SWAP1: begin
                perm_req.we    = 1'b1;
                perm_req.waddr = i_reg;
                perm_req.wdata = perm_rd;
                perm_req.raddr = a_reg + perm_rd;
                t_next         = a_reg + perm_rd;
                state_next     = rc4_pkg::ST_SWAP2;
            end
            rc4_pkg::ST_SWAP2: begin
                perm_req.we    = 1'b1;
                perm_req.waddr = j_reg;
                perm_req.wdata = a_reg;
                if (out_free) begin
                    ovalid_next = 1'b1;
                    odata_next  = din_reg ^ keystream;
                    olast_next  = dlast_reg;
                    state_next  = rc4_pkg::ST_IDLE;
                end else begin
                    // hold the read on the output entry while the result waits
                    perm_req.raddr = t_reg;
                end
            end
            rc4_pkg::ST_K_RD: begin
                perm_req.raddr = i_reg;
                state_next     = rc4_pkg::ST_K_J;
            end
            rc4_pkg::ST_K_J: begin
                a_next         = perm_rd;
                j_next         = j_sched;
                perm_req.raddr = j_sched;
                state_next     = rc4_pkg::ST_K_W1;
            end
            rc4_pkg::ST_K_W1: begin
                perm_req.we    = 1'b1;
                perm_req.waddr = i_reg;
                perm_req.wdata = perm_rd;
                state_next     = rc4_pkg::ST_K_W2;
            end
            rc4_pkg::ST_K_W2: begin
                perm_req.we    = 1'b1;
                perm_req.waddr = j_reg;
                perm_req.wdata = a_reg;
                i_next         = i_reg + byte_t'(1);
                if (i_reg == byte_t'(rc4_pkg::PERM_DEPTH - 1)) begin
                    j_next     = '0;
                    state_next = rc4_pkg::ST_IDLE;
                end else begin
                    // fetch the next step's operands behind the write
                    key_raddr  = kpos_wrap;
                    kpos_next  = kpos_wrap;
                    state_next = rc4_pkg::ST_K_J;
                end
            end
            default: begin
                state_next = state_reg;
            end
        endcase

        // item intake, shared by idle and the last swap cycle
        if (accept) begin
            if (s_tuser == rc4_pkg::FUNC_DATA) begin
                i_next     = i_reg + byte_t'(1);
                din_next   = s_tdata;
                dlast_next = s_tlast;
                state_next = rc4_pkg::ST_RD_J;
            end else begin
                key_we = key_room;
                if (key_room) begin
                    kcount_next = kcount_inc;
                end
                if (s_tlast) begin
                    klen_next   = key_room ? kcount_inc : kcount_reg;
                    kcount_next = '0;
                    kpos_next   = '0;
                    i_next      = '0;
                    j_next      = '0;
                    sched_next  = 1'b1;
                    state_next  = rc4_pkg::ST_INIT;
                end else begin
                    state_next  = rc4_pkg::ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rc4_pkg::ST_INIT;
            i_reg      <= '0;
            j_reg      <= '0;
            sched_reg  <= 1'b0;
            kcount_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            sched_reg  <= sched_next;
            kcount_reg <= kcount_next;
            ovalid_reg <= ovalid_next;
        end
        a_reg     <= a_next;
        t_reg     <= t_next;
        din_reg   <= din_next;
        dlast_reg <= dlast_next;
        klen_reg  <= klen_next;
        kpos_reg  <= kpos_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

`ifndef ASSERT_OFF
    // a data item walks the generator step without pause
    a_data_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == rc4_pkg::FUNC_DATA))
        |=> (state_reg == rc4_pkg::ST_RD_J) ##1 (state_reg == rc4_pkg::ST_SWAP1))
        else $error("data item left the generator sequence");

    // a result only appears out of the last swap cycle
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovalid_reg) |-> ($past(state_reg) == rc4_pkg::ST_SWAP2))
        else $error("result loaded outside the swap step");

    // the schedule ends with both indices and the key count cleared
    a_sched_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == rc4_pkg::ST_K_W2) && (i_reg == byte_t'(rc4_pkg::PERM_DEPTH - 1)))
        |=> (state_reg == rc4_pkg::ST_IDLE) && (i_reg == '0) && (j_reg == '0)
            && (kcount_reg == '0))
        else $error("schedule did not end cleanly");

    a_key_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        kcount_reg <= KC_W'(MAX_KEY_BYTES))
        else $error("key count beyond maximum");
`endif

endmodule

`default_nettype wire
